@@ src/fsc_pkg.sv @@
package fsc_pkg;

    localparam int COORD_W      = 24;
    localparam int COEF_W       = 16;
    localparam int ROW_W        = 3 * COEF_W;
    localparam int OFFS_W       = 24;
    localparam int RANGE_W      = 23;
    localparam int ANGLE_W      = 16;
    localparam int FRAC_W       = 14;
    localparam int PROD_W       = COEF_W + COORD_W;
    localparam int SUM_W        = PROD_W + 2;
    localparam int CW           = SUM_W + 2;
    localparam int ZW           = 22;
    localparam int ZSHIFT       = 5;
    localparam int A_W          = 15;
    localparam int CORDIC_STEPS = 19;
    // Multiply, sum, magnitude, one stage per CORDIC step, then the decision.
    localparam int PIPE_LAT     = 3 + CORDIC_STEPS + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = ROW_W;

    localparam logic [ZW-1:0]      Z_ROUND      = ZW'(16);
    localparam logic [A_W-1:0]     QUARTER_TURN = A_W'(16384);
    localparam logic [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(32768);

    // atan(2^-i) in units of pi/2^20, rounded to nearest.
    localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'd262144, 22'd154753, 22'd81767, 22'd41506, 22'd20834, 22'd10427,
        22'd5215,   22'd2608,   22'd1304,  22'd652,   22'd326,   22'd163,
        22'd81,     22'd41,     22'd20,    22'd10,    22'd5,     22'd3,
        22'd1
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ROW    = 3'd0,
        REG_Y_ROW    = 3'd1,
        REG_X_OFFSET = 3'd2,
        REG_Y_OFFSET = 3'd3,
        REG_RANGE    = 3'd4,
        REG_HALF_ANG = 3'd5,
        REG_FWD_ONLY = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] map_x;
        logic signed [COORD_W-1:0] map_y;
        logic signed [COORD_W-1:0] map_z;
        logic                      cloud_end;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      keep;
        logic                      end_of_cloud;
    } t_out_item;

    // Point and early test results that ride along the CORDIC stages.
    typedef struct packed {
        t_in_item pt;
        logic     x_neg;
        logic     origin;
        logic     range_ok;
        logic     fwd_ok;
    } t_side;

endpackage

@@ src/fsc_xform.sv @@
module fsc_xform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  fsc_pkg::t_in_item                     i_item,
    input  logic [fsc_pkg::ROW_W-1:0]             i_x_row,
    input  logic [fsc_pkg::ROW_W-1:0]             i_y_row,
    input  logic [fsc_pkg::OFFS_W-1:0]            i_x_offset,
    input  logic [fsc_pkg::OFFS_W-1:0]            i_y_offset,
    input  logic [fsc_pkg::RANGE_W-1:0]           i_range_limit,
    output logic                                  o_valid,
    output logic signed [fsc_pkg::CW-1:0]         o_u,
    output logic signed [fsc_pkg::CW-1:0]         o_v,
    output fsc_pkg::t_side                        o_side
);
    import fsc_pkg::*;

    logic signed [COEF_W-1:0] ca [3];
    logic signed [COEF_W-1:0] cb [3];
    logic signed [PROD_W-1:0] n_pa [3];
    logic signed [PROD_W-1:0] n_pb [3];
    logic signed [PROD_W-1:0] r_pa [3];
    logic signed [PROD_W-1:0] r_pb [3];
    logic                     r1_valid;
    t_in_item                 r1_pt;

    logic signed [OFFS_W+FRAC_W-1:0] xoff_s;
    logic signed [OFFS_W+FRAC_W-1:0] yoff_s;
    logic signed [SUM_W-1:0]         n_bx;
    logic signed [SUM_W-1:0]         n_by;
    logic signed [SUM_W-1:0]         r_bx;
    logic signed [SUM_W-1:0]         r_by;
    logic                            r2_valid;
    t_in_item                        r2_pt;

    logic signed [RANGE_W+FRAC_W:0]  range_s;
    logic signed [SUM_W-1:0]         abs_x;
    logic signed [SUM_W-1:0]         abs_y;
    logic                            r3_valid;
    logic signed [CW-1:0]            r_u;
    logic signed [CW-1:0]            r_v;
    t_side                           r_side;

    // Stage 1: the six coefficient products.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ca[k] = $signed(i_x_row[k*COEF_W +: COEF_W]);
            cb[k] = $signed(i_y_row[k*COEF_W +: COEF_W]);
        end
        n_pa[0] = ca[0] * i_item.map_x;
        n_pa[1] = ca[1] * i_item.map_y;
        n_pa[2] = ca[2] * i_item.map_z;
        n_pb[0] = cb[0] * i_item.map_x;
        n_pb[1] = cb[1] * i_item.map_y;
        n_pb[2] = cb[2] * i_item.map_z;
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= n_pa;
        r_pb  <= n_pb;
        r1_pt <= i_item;
    end

    // Stage 2: exact body coordinates at scale 2^-24 m.
    always_comb begin
        xoff_s = $signed({i_x_offset, {FRAC_W{1'b0}}});
        yoff_s = $signed({i_y_offset, {FRAC_W{1'b0}}});
        n_bx = SUM_W'(r_pa[0]) + SUM_W'(r_pa[1]) + SUM_W'(r_pa[2]) + SUM_W'(xoff_s);
        n_by = SUM_W'(r_pb[0]) + SUM_W'(r_pb[1]) + SUM_W'(r_pb[2]) + SUM_W'(yoff_s);
    end

    always_ff @(posedge i_clk) begin
        r_bx  <= n_bx;
        r_by  <= n_by;
        r2_pt <= r1_pt;
    end

    // Stage 3: magnitudes for the vectoring pass and the two linear tests.
    always_comb begin
        range_s = $signed({1'b0, i_range_limit, {FRAC_W{1'b0}}});
        abs_x   = r_bx[SUM_W-1] ? -r_bx : r_bx;
        abs_y   = r_by[SUM_W-1] ? -r_by : r_by;
    end

    always_ff @(posedge i_clk) begin
        r_u             <= CW'(abs_x);
        r_v             <= CW'(abs_y);
        r_side.pt       <= r2_pt;
        r_side.x_neg    <= r_bx[SUM_W-1];
        r_side.origin   <= (r_bx == '0) && (r_by == '0);
        r_side.range_ok <= r_bx < SUM_W'(range_s);
        r_side.fwd_ok   <= !r_bx[SUM_W-1] && (r_bx != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    assign o_valid = r3_valid;
    assign o_u     = r_u;
    assign o_v     = r_v;
    assign o_side  = r_side;

endmodule

@@ src/fsc_cordic_stage.sv @@
module fsc_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [fsc_pkg::CW-1:0] i_u,
    input  logic signed [fsc_pkg::CW-1:0] i_v,
    input  logic signed [fsc_pkg::ZW-1:0] i_z,
    input  fsc_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic signed [fsc_pkg::CW-1:0] o_u,
    output logic signed [fsc_pkg::CW-1:0] o_v,
    output logic signed [fsc_pkg::ZW-1:0] o_z,
    output fsc_pkg::t_side                o_side
);
    import fsc_pkg::*;

    logic signed [CW-1:0] du;
    logic signed [CW-1:0] dv;
    logic signed [ZW-1:0] dz;
    logic signed [CW-1:0] n_u;
    logic signed [CW-1:0] n_v;
    logic signed [ZW-1:0] n_z;
    logic                 r_valid;
    logic signed [CW-1:0] r_u;
    logic signed [CW-1:0] r_v;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;

    // Arithmetic shifts round toward minus infinity.
    always_comb begin
        du = i_v >>> SHIFT;
        dv = i_u >>> SHIFT;
        dz = $signed(ATAN_TAB[SHIFT]);
        if (!i_v[CW-1]) begin
            n_u = i_u + du;
            n_v = i_v - dv;
            n_z = i_z + dz;
        end else begin
            n_u = i_u - du;
            n_v = i_v + dv;
            n_z = i_z - dz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u    <= n_u;
        r_v    <= n_v;
        r_z    <= n_z;
        r_side <= i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_u     = r_u;
    assign o_v     = r_v;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

@@ src/fsc_decide.sv @@
module fsc_decide (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [fsc_pkg::ZW-1:0]  i_z,
    input  fsc_pkg::t_side                 i_side,
    input  logic [fsc_pkg::ANGLE_W-1:0]    i_half_angle,
    input  logic                           i_fwd_only,
    output logic                           o_valid,
    output fsc_pkg::t_out_item             o_result
);
    import fsc_pkg::*;

    logic signed [ZW-1:0]  zsum;
    logic signed [ZW-1:0]  zr;
    logic [A_W-1:0]        ang;
    logic [ANGLE_W-1:0]    bmag;
    t_out_item             n_result;
    logic                  r_valid;
    t_out_item             r_result;

    always_comb begin
        zsum = i_z + $signed(Z_ROUND);
        zr   = zsum >>> ZSHIFT;
        if (zr[ZW-1]) begin
            ang = '0;
        end else if (zr > $signed(ZW'(QUARTER_TURN))) begin
            ang = QUARTER_TURN;
        end else begin
            ang = zr[A_W-1:0];
        end

        // A point behind the body mirrors the angle about the y axis.
        if (i_side.origin) begin
            bmag = '0;
        end else if (i_side.x_neg) begin
            bmag = HALF_TURN - ANGLE_W'(ang);
        end else begin
            bmag = ANGLE_W'(ang);
        end

        n_result.out_x        = i_side.pt.map_x;
        n_result.out_y        = i_side.pt.map_y;
        n_result.out_z        = i_side.pt.map_z;
        n_result.end_of_cloud = i_side.pt.cloud_end;
        n_result.keep         = i_side.range_ok && (bmag < i_half_angle)
                                && (!i_fwd_only || i_side.fwd_ok);
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ src/fov_sector_point_crop_core.sv @@
// Channel   Ports                                   Handshake
// input     i_item (map_x, map_y, map_z, cloud_end)  taken when i_start && !o_busy
// result    o_result (out_x.., keep, end_of_cloud)   one cycle, marked by o_valid
// config    i_cfg_we, i_cfg_idx, i_cfg_wdata         written when i_cfg_we is high
//
// One word enters per cycle; o_busy is always low.
// Each result passes one multiply stage, one sum stage, one magnitude stage,
// 19 CORDIC stages and one decision stage.
// Synchronous active-low reset clears the valid bits and loads register defaults.
// The receiver cannot stall, so the pipeline never holds.
module fov_sector_point_crop_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  fsc_pkg::t_in_item                 i_item,
    input  logic                              i_cfg_we,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                              o_valid,
    output fsc_pkg::t_out_item                o_result
);
    import fsc_pkg::*;

    logic [ROW_W-1:0]   r_x_row;
    logic [ROW_W-1:0]   r_y_row;
    logic [OFFS_W-1:0]  r_x_offset;
    logic [OFFS_W-1:0]  r_y_offset;
    logic [RANGE_W-1:0] r_range;
    logic [ANGLE_W-1:0] r_half_angle;
    logic               r_fwd_only;

    logic                 accept;
    logic                 c_valid [CORDIC_STEPS+1];
    logic signed [CW-1:0] c_u     [CORDIC_STEPS+1];
    logic signed [CW-1:0] c_v     [CORDIC_STEPS+1];
    logic signed [ZW-1:0] c_z     [CORDIC_STEPS+1];
    t_side                c_side  [CORDIC_STEPS+1];

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_row      <= ROW_W'(16384);
            r_y_row      <= ROW_W'(32'h4000_0000);
            r_x_offset   <= '0;
            r_y_offset   <= '0;
            r_range      <= RANGE_W'(30720);
            r_half_angle <= ANGLE_W'(32751);
            r_fwd_only   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_X_ROW:    r_x_row      <= i_cfg_wdata[ROW_W-1:0];
                REG_Y_ROW:    r_y_row      <= i_cfg_wdata[ROW_W-1:0];
                REG_X_OFFSET: r_x_offset   <= i_cfg_wdata[OFFS_W-1:0];
                REG_Y_OFFSET: r_y_offset   <= i_cfg_wdata[OFFS_W-1:0];
                REG_RANGE:    r_range      <= i_cfg_wdata[RANGE_W-1:0];
                REG_HALF_ANG: r_half_angle <= i_cfg_wdata[ANGLE_W-1:0];
                REG_FWD_ONLY: r_fwd_only   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    fsc_xform u_xform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_item        (i_item),
        .i_x_row       (r_x_row),
        .i_y_row       (r_y_row),
        .i_x_offset    (r_x_offset),
        .i_y_offset    (r_y_offset),
        .i_range_limit (r_range),
        .o_valid       (c_valid[0]),
        .o_u           (c_u[0]),
        .o_v           (c_v[0]),
        .o_side        (c_side[0])
    );

    assign c_z[0] = '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        fsc_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_u     (c_u[g]),
            .i_v     (c_v[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_u     (c_u[g+1]),
            .o_v     (c_v[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    fsc_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (c_valid[CORDIC_STEPS]),
        .i_z          (c_z[CORDIC_STEPS]),
        .i_side       (c_side[CORDIC_STEPS]),
        .i_half_angle (r_half_angle),
        .i_fwd_only   (r_fwd_only),
        .o_valid      (o_valid),
        .o_result     (o_result)
    );

    // Every result word traces back to an input word taken earlier.
    a_result_has_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, PIPE_LAT))
        else $error("result word without a matching input word");

    // The point and its end mark leave unchanged, in step with the keep flag.
    a_point_passthrough : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.out_x == $past(i_item.map_x, PIPE_LAT))
                 && (o_result.out_y == $past(i_item.map_y, PIPE_LAT))
                 && (o_result.out_z == $past(i_item.map_z, PIPE_LAT))
                 && (o_result.end_of_cloud == $past(i_item.cloud_end, PIPE_LAT)))
        else $error("point fields out of step with the pipeline");

endmodule
